// ===== rtl/fit_partition_allocator_unit_assert.svh =====
// Assertion macros for the partition allocator.
// Included by modules that carry concurrent checks; no other dependencies.
`ifndef FIT_PARTITION_ALLOCATOR_UNIT_ASSERT_SVH
`define FIT_PARTITION_ALLOCATOR_UNIT_ASSERT_SVH

// same-cycle implication, disabled while reset is low
`define FPA_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("fpa assertion failed");

// next-cycle implication, disabled while reset is low
`define FPA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("fpa assertion failed");

`endif

// ===== rtl/fpa_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants, codes and types of the partition allocator.
// No dependencies.
package fpa_pkg;

    localparam int PARTITION_SLOTS = 16;
    localparam int SIZE_BITS       = 16;

    localparam int SLOT_W = (PARTITION_SLOTS > 1) ? $clog2(PARTITION_SLOTS) : 1;
    localparam int CNT_W  = $clog2(PARTITION_SLOTS + 1);

    localparam int CMD_W        = 1;
    localparam int SLOT_FIELD_W = 4;
    localparam int SIZE_FIELD_W = 16;
    localparam int STRAT_W      = 2;
    localparam int PARTS_W      = 5;
    localparam int PADDR_W      = 3;
    localparam int PDATA_W      = 32;
    localparam int REG_SEL_BIT  = 2;

    localparam logic [CMD_W-1:0] CMD_LOAD  = 1'b0;
    localparam logic [CMD_W-1:0] CMD_ALLOC = 1'b1;

    localparam logic [STRAT_W-1:0] STRAT_FIRST = 2'd0;
    localparam logic [STRAT_W-1:0] STRAT_BEST  = 2'd1;
    localparam logic [STRAT_W-1:0] STRAT_WORST = 2'd2;

    localparam logic REG_STRATEGY = 1'b0;
    localparam logic REG_PARTS    = 1'b1;

    localparam logic [STRAT_W-1:0] STRAT_RESET = STRAT_FIRST;
    localparam logic [PARTS_W-1:0] PARTS_RESET = PARTS_W'(16);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_WB,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic [STRAT_W-1:0] strategy;
        logic [PARTS_W-1:0] parts;
    } t_cfg;

    typedef struct packed {
        logic                    granted;
        logic [SLOT_FIELD_W-1:0] slot;
        logic [SIZE_FIELD_W-1:0] left_over;
        logic                    must_wait;
    } t_result;

endpackage

// ===== rtl/fpa_in_if.sv =====
`timescale 1ns / 1ps
// Request channel: valid/ready with command, slot and size.
// Depends on fpa_pkg.
interface fpa_in_if;
    logic                                valid;
    logic                                ready;
    logic [fpa_pkg::CMD_W-1:0]           command;
    logic [fpa_pkg::SLOT_FIELD_W-1:0]    slot_index;
    logic [fpa_pkg::SIZE_FIELD_W-1:0]    item_size;

    modport source (output valid, command, slot_index, item_size, input ready);
    modport sink   (input valid, command, slot_index, item_size, output ready);
endinterface

// ===== rtl/fpa_out_if.sv =====
`timescale 1ns / 1ps
// Result channel: valid/ready with grant, slot, remainder and wait flag.
// Depends on fpa_pkg.
interface fpa_out_if;
    logic                                valid;
    logic                                ready;
    logic                                granted;
    logic [fpa_pkg::SLOT_FIELD_W-1:0]    slot;
    logic [fpa_pkg::SIZE_FIELD_W-1:0]    left_over;
    logic                                must_wait;

    modport source (output valid, granted, slot, left_over, must_wait, input ready);
    modport sink   (input valid, granted, slot, left_over, must_wait, output ready);
endinterface

// ===== rtl/fpa_ram.sv =====
`timescale 1ns / 1ps
// Generic single-write, single-read synchronous RAM with a registered read port.
// No dependencies.
module fpa_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 16
) (
    input  logic                                      i_clk,
    input  logic                                      i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                          i_wdata,
    input  logic                                      i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                          o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// ===== rtl/fpa_cfg.sv =====
`timescale 1ns / 1ps
// APB register file: placement strategy and searched slot count.
// Depends on fpa_pkg.
module fpa_cfg (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [fpa_pkg::PADDR_W-1:0]   paddr,
    input  logic [fpa_pkg::PDATA_W-1:0]   pwdata,
    output logic [fpa_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready,
    output fpa_pkg::t_cfg                 o_cfg
);
    import fpa_pkg::*;

    logic [STRAT_W-1:0] r_strategy;
    logic [PARTS_W-1:0] r_parts;
    logic               wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strategy <= STRAT_RESET;
            r_parts    <= PARTS_RESET;
        end else if (wr_en) begin
            unique case (paddr[REG_SEL_BIT])
                REG_STRATEGY: r_strategy <= pwdata[STRAT_W-1:0];
                REG_PARTS:    r_parts    <= pwdata[PARTS_W-1:0];
                default:      r_strategy <= r_strategy;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[REG_SEL_BIT])
            REG_STRATEGY: prdata = PDATA_W'(r_strategy);
            REG_PARTS:    prdata = PDATA_W'(r_parts);
            default:      prdata = '0;
        endcase
    end

    assign o_cfg.strategy = r_strategy;
    assign o_cfg.parts    = r_parts;
endmodule

// ===== rtl/fpa_ctrl.sv =====
`timescale 1ns / 1ps
// Sequencer: loads slots, scans the size table for an allocate, writes back.
// Depends on fpa_pkg, fpa_in_if, fpa_out_if and the assertion macros.
`include "fit_partition_allocator_unit_assert.svh"

module fpa_ctrl (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  fpa_pkg::t_cfg                   i_cfg,
    fpa_in_if.sink                          i_req,
    fpa_out_if.source                       o_rsp,
    output logic                            o_ram_we,
    output logic [fpa_pkg::SLOT_W-1:0]      o_ram_waddr,
    output logic [fpa_pkg::SIZE_BITS-1:0]   o_ram_wdata,
    output logic                            o_ram_re,
    output logic [fpa_pkg::SLOT_W-1:0]      o_ram_raddr,
    input  logic [fpa_pkg::SIZE_BITS-1:0]   i_ram_rdata
);
    import fpa_pkg::*;

    t_state                     r_state, n_state;
    logic [SIZE_BITS-1:0]       r_size, n_size;
    logic [CNT_W-1:0]           r_iss, n_iss;
    logic                       r_ev_valid, n_ev_valid;
    logic [SLOT_W-1:0]          r_ev_idx, n_ev_idx;
    logic                       r_found, n_found;
    logic [SLOT_W-1:0]          r_best, n_best;
    logic [SIZE_BITS-1:0]       r_best_rem, n_best_rem;
    t_result                    r_res, n_res;
    logic                       r_out_valid, n_out_valid;
    t_result                    r_out, n_out;
    logic [PARTITION_SLOTS-1:0] r_slot_vld, n_slot_vld;

    logic                 in_acc;
    logic                 in_range;
    logic [CNT_W-1:0]     lim;
    logic [SIZE_BITS-1:0] in_size;
    logic [SIZE_BITS-1:0] rd_val;
    logic                 fits;
    logic [SIZE_BITS-1:0] rem;
    logic                 take;
    t_result              wait_res;

    assign i_req.ready = (r_state == ST_IDLE);
    assign in_acc      = i_req.valid && i_req.ready;
    assign in_range    = 32'(i_req.slot_index) < PARTITION_SLOTS;
    assign in_size     = SIZE_BITS'(i_req.item_size);
    assign lim         = (32'(i_cfg.parts) > PARTITION_SLOTS) ? CNT_W'(PARTITION_SLOTS)
                                                               : CNT_W'(i_cfg.parts);

    assign rd_val = r_slot_vld[r_ev_idx] ? i_ram_rdata : '0;
    assign fits   = rd_val >= r_size;
    assign rem    = rd_val - r_size;
    assign take   = fits && (!r_found
                    || ((i_cfg.strategy == STRAT_BEST) && (rem < r_best_rem))
                    || ((i_cfg.strategy == STRAT_WORST) && (rem > r_best_rem)));

    assign wait_res = '{granted: 1'b0, slot: '0, left_over: '0, must_wait: 1'b1};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_ev_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_slot_vld  <= '0;
            r_found     <= 1'b0;
            r_iss       <= '0;
        end else begin
            r_state     <= n_state;
            r_ev_valid  <= n_ev_valid;
            r_out_valid <= n_out_valid;
            r_slot_vld  <= n_slot_vld;
            r_found     <= n_found;
            r_iss       <= n_iss;
        end
    end

    always_ff @(posedge i_clk) begin
        r_size     <= n_size;
        r_ev_idx   <= n_ev_idx;
        r_best     <= n_best;
        r_best_rem <= n_best_rem;
        r_res      <= n_res;
        r_out      <= n_out;
    end

    always_comb begin
        n_state     = r_state;
        n_size      = r_size;
        n_iss       = r_iss;
        n_ev_valid  = 1'b0;
        n_ev_idx    = r_ev_idx;
        n_found     = r_found;
        n_best      = r_best;
        n_best_rem  = r_best_rem;
        n_res       = r_res;
        n_out       = r_out;
        n_slot_vld  = r_slot_vld;
        n_out_valid = r_out_valid && !o_rsp.ready;
        o_ram_we    = 1'b0;
        o_ram_waddr = SLOT_W'(i_req.slot_index);
        o_ram_wdata = in_size;
        o_ram_re    = 1'b0;
        o_ram_raddr = r_iss[SLOT_W-1:0];

        unique case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    if (i_req.command == CMD_LOAD) begin
                        o_ram_we = in_range;
                        if (in_range) begin
                            n_slot_vld[SLOT_W'(i_req.slot_index)] = 1'b1;
                        end
                        n_res.granted   = 1'b0;
                        n_res.slot      = i_req.slot_index;
                        n_res.left_over = in_range ? SIZE_FIELD_W'(in_size) : '0;
                        n_res.must_wait = 1'b0;
                        n_state         = ST_DONE;
                    end else begin
                        n_size  = in_size;
                        n_iss   = '0;
                        n_found = 1'b0;
                        if (lim == '0) begin
                            n_res   = wait_res;
                            n_state = ST_DONE;
                        end else begin
                            n_state = ST_SCAN;
                        end
                    end
                end
            end
            ST_SCAN: begin
                if (r_iss < lim) begin
                    o_ram_re   = 1'b1;
                    n_iss      = r_iss + CNT_W'(1);
                    n_ev_valid = 1'b1;
                    n_ev_idx   = r_iss[SLOT_W-1:0];
                end
                if (r_ev_valid) begin
                    if (take) begin
                        n_found    = 1'b1;
                        n_best     = r_ev_idx;
                        n_best_rem = rem;
                    end
                    if (r_iss == lim) begin
                        n_state = ST_WB;
                    end
                end
            end
            ST_WB: begin
                o_ram_waddr = r_best;
                o_ram_wdata = r_best_rem;
                if (r_found) begin
                    o_ram_we             = 1'b1;
                    n_slot_vld[r_best]   = 1'b1;
                    n_res.granted        = 1'b1;
                    n_res.slot           = SLOT_FIELD_W'(r_best);
                    n_res.left_over      = SIZE_FIELD_W'(r_best_rem);
                    n_res.must_wait      = 1'b0;
                end else begin
                    n_res = wait_res;
                end
                n_state = ST_DONE;
            end
            ST_DONE: begin
                if (!r_out_valid || o_rsp.ready) begin
                    n_out_valid = 1'b1;
                    n_out       = r_res;
                    n_state     = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    assign o_rsp.valid     = r_out_valid;
    assign o_rsp.granted   = r_out.granted;
    assign o_rsp.slot      = r_out.slot;
    assign o_rsp.left_over = r_out.left_over;
    assign o_rsp.must_wait = r_out.must_wait;

    `FPA_ASSERT_NOW(a_no_write_in_scan, i_clk, i_rst_n, o_ram_we, r_state != ST_SCAN)
    `FPA_ASSERT_NEXT(a_alloc_starts, i_clk, i_rst_n, in_acc && (i_req.command == CMD_ALLOC),
        (r_state == ST_SCAN) || (r_state == ST_DONE))
    `FPA_ASSERT_NOW(a_grant_xor_wait, i_clk, i_rst_n, r_out_valid,
        !(r_out.granted && r_out.must_wait))
    `FPA_ASSERT_NOW(a_eval_in_range, i_clk, i_rst_n, r_ev_valid,
        (CNT_W'(r_ev_idx) < lim) && (r_state == ST_SCAN))
endmodule

// ===== rtl/fit_partition_allocator_unit.sv =====
`timescale 1ns / 1ps
// Top level of the fixed-partition allocator (first, best and worst fit).
// Depends on fpa_pkg, fpa_in_if, fpa_out_if, fpa_ram, fpa_cfg, fpa_ctrl.
//
//   port     dir   handshake          word
//   i_req    in    valid/ready        command, slot_index, item_size
//   o_rsp    out   valid/ready        granted, slot, left_over, must_wait
//   apb      in    psel/penable       strategy @0x0, partitions_in_use @0x4
//
// One word is worked on at a time. A load goes from accept through ST_DONE to o_rsp.
// An allocate scans the searched slots with one table read per cycle, then passes
// through ST_WB and ST_DONE before its result is valid on o_rsp.
// A search count of 0 skips the scan and gives the wait result through ST_DONE.
// Synchronous active-low reset empties the table at once (per-slot valid bits).
// A new word is taken while the previous result still waits on o_rsp; the next
// result then holds in ST_DONE and input stalls until o_rsp drains.
module fit_partition_allocator_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [fpa_pkg::PADDR_W-1:0]   paddr,
    input  logic [fpa_pkg::PDATA_W-1:0]   pwdata,
    output logic [fpa_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready,
    fpa_in_if.sink                        i_req,
    fpa_out_if.source                     o_rsp
);
    import fpa_pkg::*;

    t_cfg                 cfg;
    logic                 ram_we;
    logic [SLOT_W-1:0]    ram_waddr;
    logic [SIZE_BITS-1:0] ram_wdata;
    logic                 ram_re;
    logic [SLOT_W-1:0]    ram_raddr;
    logic [SIZE_BITS-1:0] ram_rdata;

    fpa_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    fpa_ram #(
        .DEPTH (PARTITION_SLOTS),
        .WIDTH (SIZE_BITS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    fpa_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_req       (i_req),
        .o_rsp       (o_rsp),
        .o_ram_we    (ram_we),
        .o_ram_waddr (ram_waddr),
        .o_ram_wdata (ram_wdata),
        .o_ram_re    (ram_re),
        .o_ram_raddr (ram_raddr),
        .i_ram_rdata (ram_rdata)
    );
endmodule
